@@ hw/rtl/message_frame_segmenter_defines.svh @@
// ----------------------------------------------------------------------------
// Message frame segmenter assertion macros
// Concurrent assertion wrappers shared by the segmenter RTL files.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_FRAME_SEGMENTER_DEFINES_SVH
`define MESSAGE_FRAME_SEGMENTER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside of reset.
`define MSFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define MSFS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MSFS_ASSERT(label, prop, msg)
`define MSFS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ hw/rtl/msfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Message frame segmenter package
// Field widths, operation codes, the queue entry type and helper functions.
// ----------------------------------------------------------------------------
package msfs_pkg;

  // Field widths.
  localparam int KIND_W  = 4;
  localparam int TAG_W   = 4;
  localparam int DATA_W  = 64;
  localparam int DEST_W  = 8;
  localparam int KEEP_W  = 8;
  localparam int ID_W    = 8;
  localparam int CFG_W   = 14;
  localparam int COUNT_W = 16;
  localparam int SEQ_W   = 16;
  localparam int POP_W   = 4;

  // Message kinds and header constants.
  localparam logic [KIND_W-1:0] KIND_ENVELOPE = 4'd0;
  localparam logic [KIND_W-1:0] KIND_DATA     = 4'd1;
  localparam logic [7:0]        HDR_TYPE_DATA = 8'd2;
  localparam logic [KEEP_W-1:0] HDR_KEEP      = 8'hff;
  localparam logic [COUNT_W-1:0] FIRST_COUNT  = 16'd8;
  localparam logic [CFG_W-1:0]  MAX_FRAME_RESET = 14'd1480;

  // Command queue geometry.
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  // What the back end emits for one queued transaction.
  typedef enum logic [1:0] {
    OP_BEAT     = 2'b00,  // the beat alone
    OP_HDR_BEAT = 2'b01,  // a header, then the beat
    OP_BEAT_HDR = 2'b10   // the beat closing a frame, then a header
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [DATA_W-1:0]  beat_data;
    logic [DEST_W-1:0]  beat_dest;
    logic [KEEP_W-1:0]  beat_keep;
    logic               beat_last;
    logic [SEQ_W-1:0]   hdr_seq;
    logic [DEST_W-1:0]  hdr_dest;
    logic [ID_W-1:0]    hdr_id;
    logic [TAG_W-1:0]   hdr_tag;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Number of set bits in a keep mask.
  function automatic logic [POP_W-1:0] popcount8(input logic [KEEP_W-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < KEEP_W; i++) begin
      n = n + POP_W'(v[i]);
    end
    return n;
  endfunction

  // Header beat layout.
  function automatic logic [DATA_W-1:0] header_word(input logic [SEQ_W-1:0] seq,
                                                    input logic [DEST_W-1:0] dest,
                                                    input logic [ID_W-1:0] id,
                                                    input logic [TAG_W-1:0] tag);
    return {4'b0, tag, 8'b0, seq, HDR_TYPE_DATA, id, 8'b0, dest};
  endfunction

endpackage

@@ hw/rtl/msfs_in_if.sv @@
// ----------------------------------------------------------------------------
// Application beat channel
// Valid/ready channel that carries one application stream beat.
// ----------------------------------------------------------------------------
interface msfs_in_if
  import msfs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [TAG_W-1:0]  tag;
  logic [DATA_W-1:0] in_data;
  logic [DEST_W-1:0] in_dest;
  logic [KEEP_W-1:0] in_keep;
  logic              in_last;
  logic [ID_W-1:0]   in_id;

  modport source (
    output valid, kind, tag, in_data, in_dest, in_keep, in_last, in_id,
    input  ready
  );

  modport sink (
    input  valid, kind, tag, in_data, in_dest, in_keep, in_last, in_id,
    output ready
  );
endinterface

@@ hw/rtl/msfs_out_if.sv @@
// ----------------------------------------------------------------------------
// Network beat channel
// Valid/ready channel that carries one network stream beat.
// ----------------------------------------------------------------------------
interface msfs_out_if
  import msfs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] out_data;
  logic [DEST_W-1:0] out_dest;
  logic [KEEP_W-1:0] out_keep;
  logic              out_last;
  logic              end_of_results;

  modport source (
    output valid, out_data, out_dest, out_keep, out_last, end_of_results,
    input  ready
  );

  modport sink (
    input  valid, out_data, out_dest, out_keep, out_last, end_of_results,
    output ready
  );
endinterface

@@ hw/rtl/msfs_front.sv @@
// ----------------------------------------------------------------------------
// Segmenter front end
// Accepts application beats, tracks message and frame state, and pushes one
// command per emitted transaction group into the command queue.
// ----------------------------------------------------------------------------
`include "message_frame_segmenter_defines.svh"

module msfs_front
  import msfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  msfs_in_if.sink           app_beat,
  input  queue_status_t     q_status,
  output logic              push,
  output cmd_t              push_cmd
);

  logic [CFG_W-1:0]   max_frame_bytes;
  logic               in_message;
  logic [COUNT_W-1:0] byte_count;
  logic [SEQ_W-1:0]   seq_number;
  logic [DEST_W-1:0]  hdr_dest;
  logic [ID_W-1:0]    hdr_id;
  logic [TAG_W-1:0]   hdr_tag;

  logic               accept;
  logic [COUNT_W-1:0] count_sum;
  logic               overflow;
  logic [SEQ_W-1:0]   seq_inc;

  // Take a transaction whenever the queue has room.
  assign app_beat.ready = !q_status.full;
  assign accept         = app_beat.valid && !q_status.full;

  // Running payload count and frame overflow test.
  assign count_sum = byte_count + COUNT_W'(popcount8(app_beat.in_keep));
  assign overflow  = count_sum > COUNT_W'(max_frame_bytes);
  assign seq_inc   = seq_number + SEQ_W'(1);

  // Classify the beat and build its command.
  always_comb begin
    push               = 1'b0;
    push_cmd.op        = OP_BEAT;
    push_cmd.beat_data = app_beat.in_data;
    push_cmd.beat_dest = app_beat.in_dest;
    push_cmd.beat_keep = app_beat.in_keep;
    push_cmd.beat_last = app_beat.in_last;
    push_cmd.hdr_seq   = seq_number;
    push_cmd.hdr_dest  = hdr_dest;
    push_cmd.hdr_id    = hdr_id;
    push_cmd.hdr_tag   = hdr_tag;
    if (!in_message) begin
      if (app_beat.kind == KIND_ENVELOPE) begin
        push               = accept;
        push_cmd.beat_data = {4'b0, app_beat.tag, app_beat.in_data[55:0]};
      end else if (app_beat.kind == KIND_DATA) begin
        push              = accept;
        push_cmd.op       = OP_HDR_BEAT;
        push_cmd.hdr_seq  = '0;
        push_cmd.hdr_dest = app_beat.in_dest;
        push_cmd.hdr_id   = app_beat.in_id;
        push_cmd.hdr_tag  = app_beat.tag;
      end
    end else begin
      push = accept;
      if (overflow) begin
        push_cmd.beat_last = 1'b1;
        if (!app_beat.in_last) begin
          push_cmd.op      = OP_BEAT_HDR;
          push_cmd.hdr_seq = seq_inc;
        end
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAX_FRAME_RESET;
    end else if (cfg_wr_en) begin
      max_frame_bytes <= cfg_wr_data;
    end
  end

  // Message and frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
      byte_count <= '0;
      seq_number <= '0;
      hdr_dest   <= '0;
      hdr_id     <= '0;
      hdr_tag    <= '0;
    end else if (accept) begin
      if (!in_message) begin
        if (app_beat.kind == KIND_DATA) begin
          hdr_dest   <= app_beat.in_dest;
          hdr_id     <= app_beat.in_id;
          hdr_tag    <= app_beat.tag;
          seq_number <= '0;
          byte_count <= FIRST_COUNT;
          in_message <= !app_beat.in_last;
        end
      end else if (overflow) begin
        byte_count <= '0;
        if (app_beat.in_last) begin
          in_message <= 1'b0;
        end else begin
          seq_number <= seq_inc;
        end
      end else begin
        byte_count <= count_sum;
        if (app_beat.in_last) begin
          in_message <= 1'b0;
        end
      end
    end
  end

  // Checks on frame bookkeeping.
  `MSFS_ASSERT(a_count_cleared, (accept && in_message && overflow) |=> (byte_count == '0), "byte count not cleared after frame close")
  `MSFS_ASSERT(a_idle_after_last, (accept && in_message && app_beat.in_last) |=> !in_message, "message did not end on its last beat")

endmodule

@@ hw/rtl/msfs_queue.sv @@
// ----------------------------------------------------------------------------
// Segmenter command queue
// Small first-in first-out buffer of commands between front and back end.
// ----------------------------------------------------------------------------
`include "message_frame_segmenter_defines.svh"

module msfs_queue
  import msfs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          push_cmd,
  input  logic          pop,
  output cmd_t          head,
  output queue_status_t status
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign status.full  = count == QUEUE_CW'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign head         = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CW'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CW'(1);
      end
    end
  end

  // Occupancy checks.
  `MSFS_ASSERT(a_no_overflow, push |-> !status.full, "push into a full queue")
  `MSFS_ASSERT(a_no_underflow, pop |-> !status.empty, "pop from an empty queue")

endmodule

@@ hw/rtl/msfs_back.sv @@
// ----------------------------------------------------------------------------
// Segmenter back end
// Expands each queued command into one or two network beats and holds them
// in an output register until the receiver takes them.
// ----------------------------------------------------------------------------
`include "message_frame_segmenter_defines.svh"

module msfs_back
  import msfs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          head,
  input  queue_status_t q_status,
  output logic          pop,
  msfs_out_if.source    net_beat
);

  logic              phase;
  logic              load;
  logic              take;
  logic              single;
  logic [DATA_W-1:0] hdr_data;

  logic [DATA_W-1:0] res_data;
  logic [DEST_W-1:0] res_dest;
  logic [KEEP_W-1:0] res_keep;
  logic              res_last;
  logic              res_eor;

  logic              valid;
  logic [DATA_W-1:0] out_data;
  logic [DEST_W-1:0] out_dest;
  logic [KEEP_W-1:0] out_keep;
  logic              out_last;
  logic              end_of_results;

  // The output register refills when empty or when its beat is taken.
  assign load   = !valid || net_beat.ready;
  assign take   = load && !q_status.empty;
  assign single = (head.op != OP_HDR_BEAT) && (head.op != OP_BEAT_HDR);
  assign pop    = take && (single || phase);

  assign hdr_data = header_word(head.hdr_seq, head.hdr_dest, head.hdr_id, head.hdr_tag);

  // Pick the beat for the current phase of the head command.
  always_comb begin
    res_data = head.beat_data;
    res_dest = head.beat_dest;
    res_keep = head.beat_keep;
    res_last = head.beat_last;
    res_eor  = 1'b1;
    case (head.op)
      OP_HDR_BEAT: begin
        if (!phase) begin
          res_data = hdr_data;
          res_dest = head.hdr_dest;
          res_keep = HDR_KEEP;
          res_last = 1'b0;
          res_eor  = 1'b0;
        end
      end
      OP_BEAT_HDR: begin
        if (!phase) begin
          res_eor = 1'b0;
        end else begin
          res_data = hdr_data;
          res_dest = head.hdr_dest;
          res_keep = HDR_KEEP;
          res_last = 1'b0;
        end
      end
      default: begin
        res_eor = 1'b1;
      end
    endcase
  end

  // Phase and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      valid <= 1'b0;
    end else begin
      if (take) begin
        phase <= !single && !phase;
      end
      if (load) begin
        valid <= take;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (take) begin
      out_data       <= res_data;
      out_dest       <= res_dest;
      out_keep       <= res_keep;
      out_last       <= res_last;
      end_of_results <= res_eor;
    end
  end

  assign net_beat.valid          = valid;
  assign net_beat.out_data       = out_data;
  assign net_beat.out_dest       = out_dest;
  assign net_beat.out_keep       = out_keep;
  assign net_beat.out_last       = out_last;
  assign net_beat.end_of_results = end_of_results;

  // Expansion checks.
  `MSFS_ASSERT(a_phase_has_cmd, phase |-> !q_status.empty, "second beat pending with no command")
  `MSFS_ASSERT(a_single_ends, (take && single) |=> end_of_results, "single beat not marked as end of results")

endmodule

@@ hw/rtl/message_frame_segmenter.sv @@
// ----------------------------------------------------------------------------
// Message frame segmenter
// Cuts application stream messages into network frames with header beats.
// ----------------------------------------------------------------------------
// Usage:
//   app_beat carries application beats in, net_beat carries network beats
//   out; both are valid/ready channels and a transaction completes on a
//   clock edge with valid and ready high. cfg_wr_en/cfg_wr_data write the
//   14-bit frame byte limit; write it only while no transaction is in flight.
//   An accepted beat is written into the command queue and then loaded into
//   the output register, from which the receiver takes it. Throughput: one
//   network beat per cycle while net_beat is ready and one input beat per
//   cycle while the queue has room; a beat that adds a header yields a header
//   beat and a data beat, and the four-entry command queue absorbs it so the
//   input stalls only when the queue fills.
//   Reset (synchronous, rst high) empties the queue and output register,
//   returns to idle with all counters at zero and the limit at 1480.
//   When net_beat stalls, the output beat holds, the queue fills, and
//   app_beat.ready drops once four commands are waiting.
// ----------------------------------------------------------------------------
module message_frame_segmenter
  import msfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  msfs_in_if.sink          app_beat,
  msfs_out_if.source       net_beat
);

  logic          push;
  cmd_t          push_cmd;
  logic          pop;
  cmd_t          head;
  queue_status_t q_status;

  // Classification and frame bookkeeping.
  msfs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .app_beat    (app_beat),
    .q_status    (q_status),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // Command buffer between the two halves.
  msfs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Beat generation and output register.
  msfs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .net_beat (net_beat)
  );

endmodule
